// File: rtl/core/glr_pkg.sv
// ----------------------------------------------------------------------------
// glr_pkg
// Types and constants shared by the command line receiver modules.
// ----------------------------------------------------------------------------
`default_nettype none

package glr_pkg;

  // Result event codes
  typedef enum logic [2:0] {
    EV_DROPPED     = 3'd0,
    EV_KEPT        = 3'd1,
    EV_LINE_OK     = 3'd2,
    EV_EMPTY       = 3'd3,
    EV_BAD_NUMBER  = 3'd4,
    EV_BAD_SUM     = 3'd5,
    EV_NO_SUM      = 3'd6,
    EV_SUM_NO_NUM  = 3'd7
  } event_e;

  // Characters of interest
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_COLON = 8'h3A;
  localparam logic [7:0] CHR_SEMI  = 8'h3B;
  localparam logic [7:0] CHR_N     = 8'h4E;
  localparam logic [7:0] CHR_STAR  = 8'h2A;
  localparam logic [7:0] CHR_M     = 8'h4D;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_ONE   = 8'h31;
  localparam logic [7:0] CHR_NINE  = 8'h39;

  // Progress of the M110 match
  localparam logic [2:0] M110_FOUND = 3'd4;

  // Queue between classifier and executor
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Widths of the result fields
  localparam int unsigned LEN_W  = 7;
  localparam int unsigned NUM_W  = 32;
  localparam int unsigned SUM_W  = 9;

  // One classified byte
  typedef struct packed {
    logic [7:0] chr;
    logic [3:0] digit;
    logic       is_digit;
    logic       is_eol;    // CR or LF
    logic       is_colon;
    logic       is_semi;
    logic       is_n;
    logic       is_star;
    logic       is_m;
    logic       is_one;
    logic       is_zero;
  } rx_class_t;

endpackage

`default_nettype wire

// File: rtl/core/gcode_line_receiver_core.sv
// An accepted byte is written into the queue, then popped into the registered result beat.
// One byte per cycle unless full; the executor retires one per cycle unless stalled.
// The two-entry queue and the result register let input and output stall independently.
// Reset clears line state, the last accepted line number, the queue and the result valid.
// ----------------------------------------------------------------------------
// gcode_line_receiver_core
// Frames received bytes into command lines and checks line number and checksum.
// ----------------------------------------------------------------------------
`default_nettype none

module gcode_line_receiver_core #(
  parameter int unsigned LINE_CAPACITY = 96
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        rx_valid_i,
  output logic             rx_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             res_valid_o,
  input  wire logic        res_ready_i,
  output logic [2:0]       event_res_o,
  output logic [7:0]       kept_byte_o,
  output logic [31:0]      resend_number_o,
  output logic [6:0]       line_length_o
);
  import glr_pkg::*;

  rx_class_t cls;
  rx_class_t head;
  logic      q_full;
  logic      q_empty;
  logic      q_pop;
  logic      q_push;

  assign rx_ready_o = !q_full;
  assign q_push     = rx_valid_i && !q_full;

  // Classify incoming beats
  glr_classify u_classify (
    .rx_byte_i (rx_byte_i),
    .cls_o     (cls)
  );

  // Buffer classified bytes
  glr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (cls),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (head)
  );

  // Execute line logic
  glr_execute #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_execute (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_valid_i    (!q_empty),
    .item_i          (head),
    .item_pop_o      (q_pop),
    .res_valid_o     (res_valid_o),
    .res_ready_i     (res_ready_i),
    .event_res_o     (event_res_o),
    .kept_byte_o     (kept_byte_o),
    .resend_number_o (resend_number_o),
    .line_length_o   (line_length_o)
  );

endmodule

`default_nettype wire

// File: rtl/core/glr_classify.sv
// ----------------------------------------------------------------------------
// glr_classify
// Front end: decode each received byte into the flags the executor needs.
// ----------------------------------------------------------------------------
`default_nettype none

module glr_classify (
  input  wire logic [7:0]         rx_byte_i,
  output glr_pkg::rx_class_t      cls_o
);
  import glr_pkg::*;

  // Decode character classes
  always_comb begin
    cls_o          = '0;
    cls_o.chr      = rx_byte_i;
    cls_o.is_digit = (rx_byte_i >= CHR_ZERO) && (rx_byte_i <= CHR_NINE);
    cls_o.digit    = 4'(rx_byte_i - CHR_ZERO);
    cls_o.is_eol   = (rx_byte_i == CHR_LF) || (rx_byte_i == CHR_CR);
    cls_o.is_colon = (rx_byte_i == CHR_COLON);
    cls_o.is_semi  = (rx_byte_i == CHR_SEMI);
    cls_o.is_n     = (rx_byte_i == CHR_N);
    cls_o.is_star  = (rx_byte_i == CHR_STAR);
    cls_o.is_m     = (rx_byte_i == CHR_M);
    cls_o.is_one   = (rx_byte_i == CHR_ONE);
    cls_o.is_zero  = (rx_byte_i == CHR_ZERO);
  end

endmodule

`default_nettype wire

// File: rtl/core/glr_queue.sv
// ----------------------------------------------------------------------------
// glr_queue
// Short queue of classified bytes between the front end and the executor.
// ----------------------------------------------------------------------------
`default_nettype none

module glr_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  glr_pkg::rx_class_t      push_data_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output logic                    empty_o,
  output glr_pkg::rx_class_t      head_o
);
  import glr_pkg::*;

  rx_class_t           mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   count_q, count_d;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/glr_execute.sv
// ----------------------------------------------------------------------------
// glr_execute
// Back end: per-line state, line end checks and the registered result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module glr_execute #(
  parameter int unsigned LINE_CAPACITY = 96
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  item_valid_i,
  input  glr_pkg::rx_class_t         item_i,
  output logic                       item_pop_o,
  output logic                       res_valid_o,
  input  wire logic                  res_ready_i,
  output logic [2:0]                 event_res_o,
  output logic [7:0]                 kept_byte_o,
  output logic [glr_pkg::NUM_W-1:0]  resend_number_o,
  output logic [glr_pkg::LEN_W-1:0]  line_length_o
);
  import glr_pkg::*;

  localparam logic [LEN_W-1:0] FULL_COUNT = LEN_W'(LINE_CAPACITY - 1);

  // Line state
  logic [LEN_W-1:0] kept_count_q, kept_count_d;
  logic             in_comment_q, in_comment_d;
  logic [NUM_W-1:0] last_num_q, last_num_d;
  logic             num_seen_q, num_seen_d;
  logic             num_open_q, num_open_d;
  logic [NUM_W-1:0] num_acc_q, num_acc_d;
  logic             star_seen_q, star_seen_d;
  logic             star_open_q, star_open_d;
  logic [7:0]       xor_q, xor_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [2:0]       m110_q, m110_d;

  // Result register
  logic             out_valid_q, out_valid_d;
  event_e           ev_q, ev_d;
  logic [7:0]       kb_q, kb_d;
  logic [NUM_W-1:0] resend_q, resend_d;
  logic [LEN_W-1:0] len_q, len_d;

  logic             line_end;
  logic [NUM_W-1:0] next_num;
  logic [NUM_W+3:0] num_grown;
  logic [12:0]      sum_grown;
  logic             m110_hit;

  assign item_pop_o = item_valid_i && (!out_valid_q || res_ready_i);

  assign next_num  = last_num_q + 1'b1;
  assign line_end  = item_i.is_eol || (item_i.is_colon && !in_comment_q) ||
                     (kept_count_q >= FULL_COUNT);
  assign num_grown = ({4'b0, num_acc_q} << 3) + ({4'b0, num_acc_q} << 1) +
                     (NUM_W+4)'(item_i.digit);
  assign sum_grown = ({4'b0, sum_q} << 3) + ({4'b0, sum_q} << 1) + 13'(item_i.digit);

  // Match the next character of M110
  always_comb begin
    case (m110_q)
      3'd0:    m110_hit = item_i.is_m;
      3'd1:    m110_hit = item_i.is_one;
      3'd2:    m110_hit = item_i.is_one;
      3'd3:    m110_hit = item_i.is_zero;
      default: m110_hit = 1'b0;
    endcase
  end

  // Update line state and form the result
  always_comb begin
    kept_count_d = kept_count_q;
    in_comment_d = in_comment_q;
    last_num_d   = last_num_q;
    num_seen_d   = num_seen_q;
    num_open_d   = num_open_q;
    num_acc_d    = num_acc_q;
    star_seen_d  = star_seen_q;
    star_open_d  = star_open_q;
    xor_d        = xor_q;
    sum_d        = sum_q;
    m110_d       = m110_q;
    out_valid_d  = out_valid_q && !res_ready_i;
    ev_d         = ev_q;
    kb_d         = kb_q;
    resend_d     = resend_q;
    len_d        = len_q;

    if (item_pop_o) begin
      out_valid_d = 1'b1;
      ev_d        = EV_DROPPED;
      kb_d        = '0;
      resend_d    = '0;
      len_d       = '0;
      if (line_end) begin
        // Check the finished line
        if (kept_count_q == '0) begin
          ev_d = EV_EMPTY;
        end else begin
          len_d = kept_count_q;
          if (num_seen_q) begin
            if ((num_acc_q != next_num) && (m110_q != M110_FOUND)) begin
              ev_d     = EV_BAD_NUMBER;
              resend_d = next_num;
            end else if (!star_seen_q) begin
              ev_d     = EV_NO_SUM;
              resend_d = next_num;
            end else if (sum_q != {1'b0, xor_q}) begin
              ev_d     = EV_BAD_SUM;
              resend_d = next_num;
            end else begin
              ev_d       = EV_LINE_OK;
              last_num_d = num_acc_q;
            end
          end else if (star_seen_q) begin
            ev_d = EV_SUM_NO_NUM;
          end else begin
            ev_d = EV_LINE_OK;
          end
        end
        // Clear per-line state
        kept_count_d = '0;
        in_comment_d = 1'b0;
        num_seen_d   = 1'b0;
        num_open_d   = 1'b0;
        num_acc_d    = '0;
        star_seen_d  = 1'b0;
        star_open_d  = 1'b0;
        xor_d        = '0;
        sum_d        = '0;
        m110_d       = '0;
      end else if (in_comment_q || item_i.is_semi) begin
        // Drop comment bytes
        in_comment_d = 1'b1;
      end else begin
        // Keep the byte
        ev_d = EV_KEPT;
        kb_d = item_i.chr;
        if (!star_seen_q && !item_i.is_star) begin
          xor_d = xor_q ^ item_i.chr;
        end
        if (item_i.is_digit) begin
          if (num_open_q) begin
            num_acc_d = (num_grown[NUM_W+3:NUM_W] != '0) ? '1 : num_grown[NUM_W-1:0];
          end
          if (star_open_q) begin
            sum_d = (sum_grown > 13'd255) ? SUM_W'(256) : sum_grown[SUM_W-1:0];
          end
        end else begin
          num_open_d  = 1'b0;
          star_open_d = 1'b0;
          if (item_i.is_n && !num_seen_q) begin
            num_seen_d = 1'b1;
            num_open_d = 1'b1;
            num_acc_d  = '0;
          end
          if (item_i.is_star && !star_seen_q) begin
            star_seen_d = 1'b1;
            star_open_d = 1'b1;
            sum_d       = '0;
          end
        end
        if (m110_q != M110_FOUND) begin
          if (m110_hit) begin
            m110_d = m110_q + 1'b1;
          end else if (item_i.is_m) begin
            m110_d = 3'd1;
          end else begin
            m110_d = '0;
          end
        end
        kept_count_d = kept_count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_count_q <= '0;
      in_comment_q <= 1'b0;
      last_num_q   <= '0;
      num_seen_q   <= 1'b0;
      num_open_q   <= 1'b0;
      num_acc_q    <= '0;
      star_seen_q  <= 1'b0;
      star_open_q  <= 1'b0;
      xor_q        <= '0;
      sum_q        <= '0;
      m110_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      kept_count_q <= kept_count_d;
      in_comment_q <= in_comment_d;
      last_num_q   <= last_num_d;
      num_seen_q   <= num_seen_d;
      num_open_q   <= num_open_d;
      num_acc_q    <= num_acc_d;
      star_seen_q  <= star_seen_d;
      star_open_q  <= star_open_d;
      xor_q        <= xor_d;
      sum_q        <= sum_d;
      m110_q       <= m110_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    ev_q     <= ev_d;
    kb_q     <= kb_d;
    resend_q <= resend_d;
    len_q    <= len_d;
  end

  assign res_valid_o     = out_valid_q;
  assign event_res_o     = ev_q;
  assign kept_byte_o     = kb_q;
  assign resend_number_o = resend_q;
  assign line_length_o   = len_q;

endmodule

`default_nettype wire
